FILE: rtl/core/wspf_pkg.sv
// Shared types, codes and constants of the LED frame sequencer.
// No dependencies; the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps

package wspf_pkg;

  // Default sizes of the frame.
  localparam int unsigned LED_COUNT_DEF  = 64;
  localparam int unsigned PRE_SLOTS_DEF  = 2;
  localparam int unsigned POST_SLOTS_DEF = 2;

  // One slot is 24 compare words, GRB order, MSB first.
  localparam int unsigned WORD_IDX_W = 5;
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = 5'd23;

  // Brightness scaling: floor(p / 100) = (p * 5243) >> 19 for p up to 25500.
  localparam logic [6:0]  PCT_MAX      = 7'd100;
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [15:0] TIMER_PERIOD_RESET = 16'd59;

  // Item kinds.
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result kinds.
  localparam logic RK_WORD  = 1'b0;
  localparam logic RK_START = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  led_pos;
    logic [23:0] rgb_color;
    logic [6:0]  brightness;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] duty_word;
    logic        start_accepted;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCALE_MUL,
    ST_SCALE_DIV,
    ST_SCALE_SAVE,
    ST_TICK_READ,
    ST_TICK_LOAD,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/wspf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wspf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/ws2812_pwm_frame_sequencer.sv
// WS2812 frame sequencer: colour store, brightness scaling and PWM compare word generation.
// Depends on wspf_pkg for types and constants and on wspf_ram for the colour store.
// Flow: a set item scales its three channels in turn, each through multiply, divide and save states;
// a start response is loaded from the idle state into the output register; a slot tick passes the
// read and load states and then emits its words, one per cycle while the output does not stall.
// The 24 words of a slot leave through a single output register, one per cycle at most.
// Reset (rst, synchronous) clears control state and starts a clearing pass that writes
// zero to every colour store entry, one per cycle, with no item taken meanwhile.
`timescale 1ns / 1ps

module ws2812_pwm_frame_sequencer #(
  parameter int unsigned LED_COUNT  = wspf_pkg::LED_COUNT_DEF,
  parameter int unsigned PRE_SLOTS  = wspf_pkg::PRE_SLOTS_DEF,
  parameter int unsigned POST_SLOTS = wspf_pkg::POST_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Item channel.
  input  logic             item_valid,
  output logic             item_stall,
  input  wspf_pkg::item_t  item,
  // Result channel.
  output logic             result_valid,
  input  logic             result_stall,
  output wspf_pkg::result_t result,
  // Timer period register write channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  // Store addressing and slot counting follow from the frame shape.
  localparam int unsigned AddrW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned TotalSlots  = PRE_SLOTS + LED_COUNT + POST_SLOTS;
  localparam int unsigned SlotW       = $clog2(TotalSlots + 1);
  localparam logic [SlotW-1:0] SlotTotal  = SlotW'(TotalSlots);
  localparam logic [SlotW-1:0] SlotPre    = SlotW'(PRE_SLOTS);
  localparam logic [SlotW-1:0] SlotLedEnd = SlotW'(PRE_SLOTS + LED_COUNT);
  localparam logic [AddrW-1:0] LastAddr   = AddrW'(LED_COUNT - 1);
  localparam logic [10:0]      IndexLimit = 11'(LED_COUNT);

  wspf_pkg::state_t state, state_next;

  // Control registers.
  logic              busy;
  logic [SlotW-1:0]  slot_count;
  logic [15:0]       timer_period;
  logic [AddrW-1:0]  clr_addr;
  logic [1:0]        chan;
  logic [wspf_pkg::WORD_IDX_W-1:0] word_idx;
  logic              resp_pending;

  // Payload registers.
  logic              resp_acc;
  logic [23:0]       rgb_q;
  logic [6:0]        pct_q;
  logic [AddrW-1:0]  idx_q;
  logic [15:0]       color_acc;
  logic [27:0]       prod;
  logic              led_slot;
  logic [AddrW-1:0]  rd_addr;
  logic [23:0]       grb;
  logic [15:0]       duty_hi;
  logic [15:0]       duty_lo;

  // Strobes from the output decoder.
  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              ram_we;
  logic [AddrW-1:0]  ram_wr_addr;
  logic [23:0]       ram_wr_data;
  logic [23:0]       ram_rd_data;
  wspf_pkg::result_t out_word;

  // Shared multiplier: channel times percent, then product times the reciprocal of 100.
  logic [14:0]       mul_a;
  logic [12:0]       mul_b;
  logic [27:0]       mul_p;
  logic [7:0]        scaled;

  // Duty words from the timer period; the add and shifts are registered in the tick read state.
  logic [16:0]       arr;
  logic [18:0]       arr_x3;
  logic [16:0]       hi_raw;
  logic [14:0]       lo_raw;

  logic              set_ok;
  logic              tick_live;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign cfg_ready = 1'b1;

  assign set_ok    = ({1'b0, item.led_pos} < IndexLimit);
  assign tick_live = busy && (slot_count < SlotTotal);

  always_comb begin
    mul_a = 15'd0;
    mul_b = 13'd0;
    if (state == wspf_pkg::ST_SCALE_DIV) begin
      mul_a = prod[14:0];
      mul_b = wspf_pkg::DIV100_RECIP;
    end else begin
      mul_a = {7'd0, rgb_q[23:16]};
      mul_b = {6'd0, pct_q};
    end
  end

  assign mul_p  = {13'd0, mul_a} * {15'd0, mul_b};
  assign scaled = prod[wspf_pkg::DIV100_SHIFT +: 8];

  assign arr    = {1'b0, timer_period} + 17'd1;
  assign arr_x3 = {2'b00, arr} + {1'b0, arr, 1'b0};
  assign hi_raw = arr_x3[18:2];
  assign lo_raw = arr[16:2];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      wspf_pkg::ST_CLEAR: begin
        if (clr_addr == LastAddr) begin
          state_next = wspf_pkg::ST_IDLE;
        end
      end
      wspf_pkg::ST_IDLE: begin
        if (accept && resp_pending == 1'b0) begin
          if (item.kind == wspf_pkg::KIND_SET && set_ok) begin
            state_next = wspf_pkg::ST_SCALE_MUL;
          end else if (item.kind == wspf_pkg::KIND_TICK && tick_live) begin
            state_next = wspf_pkg::ST_TICK_READ;
          end
        end
      end
      wspf_pkg::ST_SCALE_MUL:  state_next = wspf_pkg::ST_SCALE_DIV;
      wspf_pkg::ST_SCALE_DIV:  state_next = wspf_pkg::ST_SCALE_SAVE;
      wspf_pkg::ST_SCALE_SAVE: begin
        state_next = (chan == 2'd2) ? wspf_pkg::ST_IDLE : wspf_pkg::ST_SCALE_MUL;
      end
      wspf_pkg::ST_TICK_READ:  state_next = wspf_pkg::ST_TICK_LOAD;
      wspf_pkg::ST_TICK_LOAD:  state_next = wspf_pkg::ST_EMIT;
      wspf_pkg::ST_EMIT: begin
        if (out_free && word_idx == wspf_pkg::LAST_WORD) begin
          state_next = wspf_pkg::ST_IDLE;
        end
      end
      default: state_next = wspf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: stall, store write and output register load.
  always_comb begin
    item_stall  = (state != wspf_pkg::ST_IDLE) || resp_pending;
    ram_we      = 1'b0;
    ram_wr_addr = idx_q;
    ram_wr_data = {color_acc, scaled};
    out_load    = 1'b0;
    out_word    = '0;
    unique case (state)
      wspf_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = 24'd0;
      end
      wspf_pkg::ST_SCALE_SAVE: begin
        ram_we = (chan == 2'd2);
      end
      wspf_pkg::ST_EMIT: begin
        out_load                = out_free;
        out_word.result_kind    = wspf_pkg::RK_WORD;
        out_word.duty_word      = !led_slot ? 16'd0 : (grb[23] ? duty_hi : duty_lo);
        out_word.start_accepted = 1'b0;
        out_word.last           = (word_idx == wspf_pkg::LAST_WORD);
      end
      default: begin
        // A start response leaves from the idle state once the output register frees up.
        if (resp_pending) begin
          out_load                = out_free;
          out_word.result_kind    = wspf_pkg::RK_START;
          out_word.duty_word      = 16'd0;
          out_word.start_accepted = resp_acc;
          out_word.last           = 1'b1;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wspf_pkg::ST_CLEAR;
      busy         <= 1'b0;
      slot_count   <= '0;
      timer_period <= wspf_pkg::TIMER_PERIOD_RESET;
      clr_addr     <= '0;
      chan         <= 2'd0;
      word_idx     <= '0;
      resp_pending <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        timer_period <= cfg_data;
      end

      if (state == wspf_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AddrW'(1);
      end

      if (accept && item.kind == wspf_pkg::KIND_START) begin
        resp_pending <= 1'b1;
        if (!busy) begin
          busy       <= 1'b1;
          slot_count <= '0;
        end
      end else if (out_load && state == wspf_pkg::ST_IDLE) begin
        resp_pending <= 1'b0;
      end

      if (accept && item.kind == wspf_pkg::KIND_TICK && busy) begin
        if (tick_live) begin
          slot_count <= slot_count + SlotW'(1);
        end else begin
          busy       <= 1'b0;
          slot_count <= '0;
        end
      end

      if (accept) begin
        chan <= 2'd0;
      end else if (state == wspf_pkg::ST_SCALE_SAVE) begin
        chan <= chan + 2'd1;
      end

      // The counter holds at the last word once the slot is done.
      if (state == wspf_pkg::ST_TICK_LOAD) begin
        word_idx <= '0;
      end else if (state == wspf_pkg::ST_EMIT && out_free &&
                   word_idx != wspf_pkg::LAST_WORD) begin
        word_idx <= word_idx + wspf_pkg::WORD_IDX_W'(1);
      end

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      rgb_q    <= item.rgb_color;
      pct_q    <= (item.brightness > wspf_pkg::PCT_MAX) ? wspf_pkg::PCT_MAX : item.brightness;
      idx_q    <= item.led_pos[AddrW-1:0];
      resp_acc <= !busy;
      led_slot <= (slot_count >= SlotPre) && (slot_count < SlotLedEnd);
      rd_addr  <= AddrW'(slot_count - SlotPre);
    end
    if (state == wspf_pkg::ST_SCALE_MUL || state == wspf_pkg::ST_SCALE_DIV) begin
      prod <= mul_p;
    end
    if (state == wspf_pkg::ST_SCALE_SAVE) begin
      color_acc <= {color_acc[7:0], scaled};
      rgb_q     <= {rgb_q[15:0], 8'd0};
    end
    if (state == wspf_pkg::ST_TICK_READ) begin
      duty_hi <= (hi_raw == 17'd0) ? 16'd0 : 16'(hi_raw - 17'd1);
      duty_lo <= (lo_raw == 15'd0) ? 16'd0 : {1'b0, lo_raw - 15'd1};
    end
    if (state == wspf_pkg::ST_TICK_LOAD) begin
      // Stored as RRGGBB, sent as GGRRBB.
      grb <= {ram_rd_data[15:8], ram_rd_data[23:16], ram_rd_data[7:0]};
    end else if (state == wspf_pkg::ST_EMIT && out_free) begin
      grb <= {grb[22:0], 1'b0};
    end
    if (out_load) begin
      result <= out_word;
    end
  end

  wspf_ram #(
    .WIDTH (24),
    .DEPTH (LED_COUNT)
  ) u_color_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // A compare word is only produced while a frame is running.
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (state == wspf_pkg::ST_EMIT) |-> busy)
    else $error("compare word emitted outside a frame");

  // The slot counter never runs past the end of the frame.
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= SlotTotal)
    else $error("slot counter beyond frame length");

  // An accepted start leaves the block busy when its response is loaded.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (out_load && state == wspf_pkg::ST_IDLE && resp_acc) |-> busy)
    else $error("accepted start without a running frame");

  // The word counter stays inside one slot.
  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    word_idx <= wspf_pkg::LAST_WORD)
    else $error("word counter beyond slot");

  // A response load and a slot word load never coincide.
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    (state == wspf_pkg::ST_EMIT) |-> !resp_pending)
    else $error("start response pending during slot emission");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the WS2812 frame sequencer: drives set, start and tick items,
// rewrites the timer period between phases and checks every compare word and start response.
// Depends on wspf_pkg for the item and result structs, the kind codes and the frame sizes.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LEDS           = wspf_pkg::LED_COUNT_DEF;
  localparam int unsigned PRE            = wspf_pkg::PRE_SLOTS_DEF;
  localparam int unsigned POST           = wspf_pkg::POST_SLOTS_DEF;
  localparam int unsigned TOTAL_SLOTS    = PRE + LEDS + POST;
  localparam int unsigned WORDS_PER_SLOT = 24;
  localparam int unsigned ITEM_W         = $bits(wspf_pkg::item_t);
  // Kind 3 has no meaning; the block must drop it.
  localparam logic [1:0]  KIND_NONE      = 2'd3;
  // Long enough to cover any tick or set item still in flight.
  localparam int unsigned HOLD_OFF       = 40;
  localparam int unsigned LIMIT_CYCLES   = 1000000;
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam int unsigned PHASES         = 6;

  // Tracks the colour store, frame progress and timer period, and keeps the
  // words and start responses that the block still owes.
  class led_frame_scoreboard;
    logic [23:0]       colors [LEDS];
    bit                frame_on;
    int unsigned       slot;
    logic [15:0]       period;
    wspf_pkg::result_t pending_words [$];
    int unsigned       mismatches;

    function new();
      foreach (colors[i]) colors[i] = '0;
      frame_on   = 1'b0;
      slot       = 0;
      period     = wspf_pkg::TIMER_PERIOD_RESET;
      mismatches = 0;
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function logic [7:0] scale(logic [7:0] chan, logic [6:0] pct);
      int unsigned p;
      p = (pct > wspf_pkg::PCT_MAX) ? wspf_pkg::PCT_MAX : pct;
      return 8'((chan * p) / 100);
    endfunction

    function logic [15:0] minus_one(int unsigned v);
      return (v == 0) ? 16'd0 : 16'(v - 1);
    endfunction

    // Updates the model for one accepted item and queues what it causes.
    // Returns 0 when the block should simply drop the item.
    function bit take_item(wspf_pkg::item_t it);
      wspf_pkg::result_t w;
      logic [23:0]       c;
      logic [23:0]       grb;
      int unsigned       s;
      int unsigned       arr;
      logic [15:0]       hi;
      logic [15:0]       lo;
      w = '0;
      case (it.kind)
        wspf_pkg::KIND_SET: begin
          if (it.led_pos >= LEDS) return 1'b0;
          colors[it.led_pos] = {scale(it.rgb_color[23:16], it.brightness),
                                scale(it.rgb_color[15:8], it.brightness),
                                scale(it.rgb_color[7:0], it.brightness)};
          return 1'b1;
        end
        wspf_pkg::KIND_START: begin
          w.result_kind    = wspf_pkg::RK_START;
          w.start_accepted = !frame_on;
          w.last           = 1'b1;
          pending_words.push_back(w);
          if (!frame_on) begin
            frame_on = 1'b1;
            slot     = 0;
          end
          return 1'b1;
        end
        wspf_pkg::KIND_TICK: begin
          if (!frame_on) return 1'b0;
          // The tick after the final post slot closes the frame silently.
          if (slot >= TOTAL_SLOTS) begin
            frame_on = 1'b0;
            slot     = 0;
            return 1'b1;
          end
          s    = slot;
          slot = s + 1;
          grb  = '0;
          hi   = '0;
          lo   = '0;
          if (s >= PRE && s < PRE + LEDS) begin
            c   = colors[s - PRE];
            grb = {c[15:8], c[23:16], c[7:0]};
            arr = int'(period) + 1;
            hi  = minus_one((3 * arr) / 4);
            lo  = minus_one(arr / 4);
          end
          for (int k = 0; k < WORDS_PER_SLOT; k++) begin
            w.result_kind    = wspf_pkg::RK_WORD;
            w.start_accepted = 1'b0;
            w.last           = (k == WORDS_PER_SLOT - 1);
            if (s >= PRE && s < PRE + LEDS) w.duty_word = grb[23 - k] ? hi : lo;
            else w.duty_word = '0;
            pending_words.push_back(w);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void check_word(wspf_pkg::result_t got);
      wspf_pkg::result_t want;
      string             want_s;
      string             got_s;
      if (pending_words.size() == 0) begin
        complain($sformatf("unexpected result: kind %0d duty %0d accepted %0d last %0d",
                           got.result_kind, got.duty_word, got.start_accepted, got.last));
        return;
      end
      want = pending_words.pop_front();
      if (got.result_kind !== want.result_kind || got.duty_word !== want.duty_word ||
          got.start_accepted !== want.start_accepted || got.last !== want.last) begin
        want_s = $sformatf("kind %0d duty %0d accepted %0d last %0d",
                           want.result_kind, want.duty_word, want.start_accepted, want.last);
        got_s  = $sformatf("kind %0d duty %0d accepted %0d last %0d",
                           got.result_kind, got.duty_word, got.start_accepted, got.last);
        complain({"result mismatch: expected ", want_s, ", got ", got_s});
      end
    endfunction
  endclass

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  wspf_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  wspf_pkg::result_t result;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data     = '0;

  led_frame_scoreboard sb = new();

  bit          calm         = 1'b0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  int unsigned free_left    = 0;

  ws2812_pwm_frame_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Run limit: far beyond the slowest legal run, so only a hang trips it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts between free stretches of varying length,
  // switched off for the last phase.
  always @(negedge clk) begin
    if (calm) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left    <= free_left - 1;
      result_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      result_stall <= 1'b1;
    end else begin
      free_left    <= $urandom_range(0, 30);
      result_stall <= 1'b0;
    end
  end

  // Every result transfer is checked against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_word(result);
  end

  function automatic wspf_pkg::item_t mk(logic [1:0] kind, logic [9:0] idx, logic [23:0] rgb,
                                         logic [6:0] pct);
    wspf_pkg::item_t it;
    it.kind       = kind;
    it.led_pos    = idx;
    it.rgb_color  = rgb;
    it.brightness = pct;
    return it;
  endfunction

  // Mostly well-formed traffic: while a frame runs, ticks dominate so frames complete;
  // while idle, colours are loaded and frames started. A slice of everything is noise
  // with all fields random, which also covers the out-of-range index and kind 3.
  function automatic wspf_pkg::item_t random_item(bit frame_on);
    int unsigned     roll;
    wspf_pkg::item_t it;
    roll = $urandom_range(0, 99);
    it = mk(wspf_pkg::KIND_SET, 10'($urandom_range(0, LEDS - 1)), 24'($urandom),
            7'($urandom_range(0, 127)));
    if ($urandom_range(0, 9) == 0) it.led_pos = 10'($urandom);
    if ($urandom_range(0, 6) == 0) it.brightness = wspf_pkg::PCT_MAX;
    if (frame_on) begin
      if (roll < 72) it.kind = wspf_pkg::KIND_TICK;
      else if (roll < 88) it.kind = wspf_pkg::KIND_SET;
      else if (roll < 93) it.kind = wspf_pkg::KIND_START;
      else it = wspf_pkg::item_t'(ITEM_W'({$urandom, $urandom}));
    end else begin
      if (roll < 55) it.kind = wspf_pkg::KIND_SET;
      else if (roll < 85) it.kind = wspf_pkg::KIND_START;
      else it = wspf_pkg::item_t'(ITEM_W'({$urandom, $urandom}));
    end
    return it;
  endfunction

  // Presents one item and holds it until the block takes it. Valid stays high on
  // return so that a following item goes out back to back.
  task automatic send_item(input wspf_pkg::item_t it, output bit counted);
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    counted = sb.take_item(it);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 7)) begin
        @(negedge clk);
        item_valid <= 1'b0;
      end
    end
  endtask

  // Stops sending, waits for every owed result, then lets in-flight work settle.
  task automatic drain_and_settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.period = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    wspf_pkg::item_t directed [$];
    logic [15:0]     periods [PHASES];
    bit              counted;
    int unsigned     counted_items;

    // Phase settings: the smallest legal period, periods where a word would drop
    // below zero, the reset value, a random one, and the largest.
    periods = '{16'd3, 16'd0, wspf_pkg::TIMER_PERIOD_RESET, 16'd0, 16'd2, 16'hFFFF};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Colours at both ends of the store and of each field, a clamped
    // brightness, two dropped indexes, kind 3, a tick with no frame, a rejected start,
    // and a colour rewritten mid-frame for an LED whose slot is still to come.
    directed.push_back(mk(wspf_pkg::KIND_SET, 10'd0, 24'hFFFFFF, 7'd100));
    directed.push_back(mk(wspf_pkg::KIND_SET, 10'd63, 24'h123456, 7'd127));
    directed.push_back(mk(wspf_pkg::KIND_SET, 10'd1, 24'hA5C33C, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_SET, 10'd2, 24'h800001, 7'd1));
    directed.push_back(mk(wspf_pkg::KIND_SET, 10'd64, 24'hFFFFFF, 7'd100));
    directed.push_back(mk(wspf_pkg::KIND_SET, 10'd1023, 24'h000000, 7'd127));
    directed.push_back(mk(KIND_NONE, 10'd1023, 24'hFFFFFF, 7'd127));
    directed.push_back(mk(wspf_pkg::KIND_TICK, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_START, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_START, 10'd5, 24'h00FF00, 7'd50));
    directed.push_back(mk(wspf_pkg::KIND_TICK, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_TICK, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_TICK, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_SET, 10'd1, 24'hFF00FF, 7'd50));
    directed.push_back(mk(wspf_pkg::KIND_TICK, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_TICK, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_START, 10'd0, 24'h000000, 7'd0));
    directed.push_back(mk(wspf_pkg::KIND_TICK, 10'd0, 24'h000000, 7'd0));

    write_period(16'hFFFF);
    foreach (directed[i]) begin
      sender_gap();
      send_item(directed[i], counted);
    end

    // Random phases, each under its own timer period. A frame may span phases, so
    // period changes also land between slots of a running frame.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      calm = (ph == PHASES - 1);
      if (ph == 3) write_period(16'($urandom_range(3, 65535)));
      else write_period(periods[ph]);
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        // Now and then the sender holds off until the block has caught up.
        if (!calm && sb.frame_on && $urandom_range(0, 49) == 0) begin
          @(negedge clk);
          item_valid <= 1'b0;
          while (sb.pending_words.size() != 0) @(posedge clk);
        end
        sender_gap();
        send_item(random_item(sb.frame_on), counted);
        if (counted) counted_items++;
      end
    end

    drain_and_settle();
    if (sb.pending_words.size() != 0)
      sb.complain($sformatf("%0d results never arrived", sb.pending_words.size()));

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
